FILE: rtl/corner_color_gradient_fill_top_defines.svh
// Assertion helpers used by the checker file of the gradient fill block.
`ifndef CORNER_COLOR_GRADIENT_FILL_TOP_DEFINES_SVH
`define CORNER_COLOR_GRADIENT_FILL_TOP_DEFINES_SVH

// Same-cycle implication, switched off while reset is held.
`define CCGF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define CCGF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Implication after a fixed number of cycles.
`define CCGF_ASSERT_DELAY(label, clk, rst_n, ante, dly, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
    else $error(msg);

`endif

FILE: rtl/ccgf_pkg.sv
`default_nettype none

package ccgf_pkg;

  localparam int CH_W      = 8;
  localparam int NUM_CH    = 3;
  localparam int NUM_LANE  = 4;
  localparam int COLOR_W   = NUM_CH * CH_W;
  localparam int COORD_W   = 12;
  localparam int DIM_CFG_W = 13;
  localparam int COUNT_W   = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = COLOR_W;

  localparam int MAX_DIM_DEFAULT = 4096;

  localparam logic [DIM_CFG_W-1:0] AREA_W_RESET = DIM_CFG_W'(80);
  localparam logic [DIM_CFG_W-1:0] AREA_H_RESET = DIM_CFG_W'(40);

  // Fill selection by colour count; four and above is the bilinear blend.
  localparam logic [COUNT_W-1:0] COUNT_BG     = COUNT_W'(0);
  localparam logic [COUNT_W-1:0] COUNT_FLAT   = COUNT_W'(1);
  localparam logic [COUNT_W-1:0] COUNT_HBLEND = COUNT_W'(2);
  localparam logic [COUNT_W-1:0] COUNT_TRI    = COUNT_W'(3);

  // One restoring step per quotient bit.
  localparam int DIV_STAGES = CH_W;
  // Clock edges from the edge that takes an item to the edge that takes its result.
  localparam int LATENCY = 6 + DIV_STAGES;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLOR_COUNT  = 3'd0,
    REG_TOP_LEFT     = 3'd1,
    REG_TOP_RIGHT    = 3'd2,
    REG_BOTTOM_LEFT  = 3'd3,
    REG_BOTTOM_RIGHT = 3'd4,
    REG_BACKGROUND   = 3'd5,
    REG_AREA_WIDTH   = 3'd6,
    REG_AREA_HEIGHT  = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_HOLE  = 2'd0,
    KIND_SOLID = 2'd1,
    KIND_BLEND = 2'd2,
    KIND_TRI   = 2'd3
  } kind_t;

  // Control that travels alongside each item through the pipeline.
  typedef struct packed {
    logic                 valid;
    kind_t                kind;
    logic [COLOR_W-1:0]   solid;
  } side_t;

endpackage

`default_nettype wire

FILE: rtl/corner_color_gradient_fill_top.sv
`default_nettype none

// Corner colour gradient fill: one RGB888 pixel per clock while busy is low.
// Configuration: write cfg_wdata to register cfg_index while cfg_we is high. Indexes are
// colour count, the four corner colours, the background colour, area width and height.
// Write only while no item is in flight; busy is high for the cycle after each write.
// Input: an item (in_pixel_x, in_pixel_y) is taken at an edge where start is high and busy
// is low. A new item may be taken at every edge where busy is low, so the rate is one pixel per cycle.
// Output: out_valid is high for one cycle with out_red, out_green, out_blue and
// out_written. The result of an item passes the input register, four stages of weight
// and product work, an eight-stage restoring divider, one quotient bit per stage, and
// the output register.
// The receiver cannot stall, so results leave in item order with no backpressure.
// Reset (rst_n low at an edge) clears the configuration to its defaults (count 0, colours
// black, area 80 by 40), drops every item in flight and holds busy high for one cycle.
module corner_color_gradient_fill_top #(
  parameter int MAX_DIM = ccgf_pkg::MAX_DIM_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [ccgf_pkg::COORD_W-1:0]      in_pixel_x,
  input  logic [ccgf_pkg::COORD_W-1:0]      in_pixel_y,
  output logic                              out_valid,
  output logic [ccgf_pkg::CH_W-1:0]         out_red,
  output logic [ccgf_pkg::CH_W-1:0]         out_green,
  output logic [ccgf_pkg::CH_W-1:0]         out_blue,
  output logic                              out_written,
  input  logic                              cfg_we,
  input  logic [ccgf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ccgf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int DIM_CFG_MAX = (2 ** ccgf_pkg::DIM_CFG_W) - 1;
  localparam int DIM_CAP     = (MAX_DIM < DIM_CFG_MAX) ? MAX_DIM : DIM_CFG_MAX;
  localparam int DW          = $clog2(DIM_CAP);
  localparam int WW          = 2 * DW;
  localparam int NW          = WW + ccgf_pkg::CH_W;

  // Configuration registers.
  logic [ccgf_pkg::COUNT_W-1:0]                           count_r;
  logic [ccgf_pkg::NUM_LANE-1:0][ccgf_pkg::COLOR_W-1:0]   corner_r;
  logic [ccgf_pkg::COLOR_W-1:0]                           bg_r;
  logic [ccgf_pkg::DIM_CFG_W-1:0]                         area_w_r;
  logic [ccgf_pkg::DIM_CFG_W-1:0]                         area_h_r;
  logic                                                   busy_r;

  // Values derived from the configuration, reloaded every cycle.
  logic [DW-1:0] wm1_r;
  logic [DW-1:0] hm1_r;
  logic [DW-1:0] dx_d;
  logic [DW-1:0] dy_d;
  logic [WW-1:0] div_nxt;
  logic [WW-1:0] div_r;

  logic                          s1_valid_r;
  logic [ccgf_pkg::COORD_W-1:0]  x_r;
  logic [ccgf_pkg::COORD_W-1:0]  y_r;

  ccgf_pkg::side_t                        side3;
  logic [ccgf_pkg::NUM_LANE-1:0][WW-1:0]  weight3;

  ccgf_pkg::side_t                                          side4_r;
  logic [ccgf_pkg::NUM_CH-1:0][ccgf_pkg::NUM_LANE-1:0][NW-1:0] prod4_r;
  ccgf_pkg::side_t                                          side5_r;
  logic [ccgf_pkg::NUM_CH-1:0][NW-1:0]                      num5_r;
  ccgf_pkg::side_t                                          side_line_r [ccgf_pkg::DIV_STAGES];
  logic [ccgf_pkg::NUM_CH-1:0][ccgf_pkg::CH_W-1:0]          quo;

  ccgf_pkg::side_t                 side_last;
  logic [ccgf_pkg::COLOR_W-1:0]    rgb_nxt;
  logic                            written_nxt;
  logic                            out_valid_r;
  logic [ccgf_pkg::COLOR_W-1:0]    rgb_r;
  logic                            written_r;

  // Clamped dimension less one: zero counts as one, and the top is the dimension limit.
  function automatic logic [DW-1:0] dim_less_one(input logic [ccgf_pkg::DIM_CFG_W-1:0] d);
    logic [DW-1:0] r;
    if (d == '0) begin
      r = '0;
    end else if (32'(d) > DIM_CAP) begin
      r = DW'(DIM_CAP - 1);
    end else begin
      r = DW'(d - 1'b1);
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      corner_r <= '0;
      bg_r     <= '0;
      area_w_r <= ccgf_pkg::AREA_W_RESET;
      area_h_r <= ccgf_pkg::AREA_H_RESET;
    end else if (cfg_we) begin
      unique case (ccgf_pkg::cfg_reg_t'(cfg_index))
        ccgf_pkg::REG_COLOR_COUNT:  count_r     <= cfg_wdata[ccgf_pkg::COUNT_W-1:0];
        ccgf_pkg::REG_TOP_LEFT:     corner_r[0] <= cfg_wdata;
        ccgf_pkg::REG_TOP_RIGHT:    corner_r[1] <= cfg_wdata;
        ccgf_pkg::REG_BOTTOM_LEFT:  corner_r[2] <= cfg_wdata;
        ccgf_pkg::REG_BOTTOM_RIGHT: corner_r[3] <= cfg_wdata;
        ccgf_pkg::REG_BACKGROUND:   bg_r        <= cfg_wdata;
        ccgf_pkg::REG_AREA_WIDTH:   area_w_r    <= cfg_wdata[ccgf_pkg::DIM_CFG_W-1:0];
        ccgf_pkg::REG_AREA_HEIGHT:  area_h_r    <= cfg_wdata[ccgf_pkg::DIM_CFG_W-1:0];
      endcase
    end
  end

  // Busy covers the cycle in which the derived dimensions catch up with a write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= cfg_we;
    end
  end

  assign busy = busy_r;

  always_comb begin
    dx_d = (wm1_r == '0) ? DW'(1) : wm1_r;
    dy_d = (hm1_r == '0) ? DW'(1) : hm1_r;
    if (count_r == ccgf_pkg::COUNT_HBLEND) begin
      div_nxt = WW'(dx_d);
    end else begin
      div_nxt = WW'(dx_d) * WW'(dy_d);
    end
  end

  always_ff @(posedge clk) begin
    wm1_r <= dim_less_one(area_w_r);
    hm1_r <= dim_less_one(area_h_r);
    div_r <= div_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= start && !busy_r;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= in_pixel_x;
    y_r <= in_pixel_y;
  end

  ccgf_weights #(
    .DW (DW),
    .WW (WW)
  ) u_weights (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_i  (s1_valid_r),
    .x_i      (x_r),
    .y_i      (y_r),
    .count_i  (count_r),
    .wm1_i    (wm1_r),
    .hm1_i    (hm1_r),
    .div_i    (div_r),
    .bg_i     (bg_r),
    .flat_i   (corner_r[0]),
    .side_o   (side3),
    .weight_o (weight3)
  );

  // Weight times corner channel, one product per lane and channel.
  always_ff @(posedge clk) begin
    for (int ch = 0; ch < ccgf_pkg::NUM_CH; ch++) begin
      for (int ln = 0; ln < ccgf_pkg::NUM_LANE; ln++) begin
        prod4_r[ch][ln] <= NW'(weight3[ln]) *
          NW'(corner_r[ln][ccgf_pkg::COLOR_W-1-ch*ccgf_pkg::CH_W -: ccgf_pkg::CH_W]);
      end
    end
  end

  // The weights add up to the divisor, so the numerator stays below 256 times it.
  always_ff @(posedge clk) begin
    for (int ch = 0; ch < ccgf_pkg::NUM_CH; ch++) begin
      num5_r[ch] <= prod4_r[ch][0] + prod4_r[ch][1] + prod4_r[ch][2] + prod4_r[ch][3];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side4_r <= '0;
      side5_r <= '0;
      for (int s = 0; s < ccgf_pkg::DIV_STAGES; s++) begin
        side_line_r[s] <= '0;
      end
    end else begin
      side4_r        <= side3;
      side5_r        <= side4_r;
      side_line_r[0] <= side5_r;
      for (int s = 1; s < ccgf_pkg::DIV_STAGES; s++) begin
        side_line_r[s] <= side_line_r[s-1];
      end
    end
  end

  for (genvar ch = 0; ch < ccgf_pkg::NUM_CH; ch++) begin : g_chan
    ccgf_div_pipe #(
      .NW  (NW),
      .DVW (WW),
      .QW  (ccgf_pkg::CH_W)
    ) u_div (
      .clk   (clk),
      .num_i (num5_r[ch]),
      .div_i (div_r),
      .quo_o (quo[ch])
    );
  end

  assign side_last = side_line_r[ccgf_pkg::DIV_STAGES-1];

  always_comb begin
    unique case (side_last.kind)
      ccgf_pkg::KIND_SOLID: begin
        rgb_nxt     = side_last.solid;
        written_nxt = 1'b1;
      end
      ccgf_pkg::KIND_BLEND: begin
        rgb_nxt     = {quo[0], quo[1], quo[2]};
        written_nxt = 1'b1;
      end
      default: begin
        rgb_nxt     = '0;
        written_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= side_last.valid;
    end
  end

  always_ff @(posedge clk) begin
    rgb_r     <= rgb_nxt;
    written_r <= written_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_red     = rgb_r[ccgf_pkg::COLOR_W-1 -: ccgf_pkg::CH_W];
  assign out_green   = rgb_r[ccgf_pkg::COLOR_W-1-ccgf_pkg::CH_W -: ccgf_pkg::CH_W];
  assign out_blue    = rgb_r[ccgf_pkg::CH_W-1:0];
  assign out_written = written_r;

endmodule

`default_nettype wire

FILE: rtl/ccgf_weights.sv
`default_nettype none

module ccgf_weights #(
  parameter int DW = ccgf_pkg::COORD_W,
  parameter int WW = 2 * DW
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   valid_i,
  input  logic [ccgf_pkg::COORD_W-1:0]           x_i,
  input  logic [ccgf_pkg::COORD_W-1:0]           y_i,
  input  logic [ccgf_pkg::COUNT_W-1:0]           count_i,
  input  logic [DW-1:0]                          wm1_i,
  input  logic [DW-1:0]                          hm1_i,
  input  logic [WW-1:0]                          div_i,
  input  logic [ccgf_pkg::COLOR_W-1:0]           bg_i,
  input  logic [ccgf_pkg::COLOR_W-1:0]           flat_i,
  output ccgf_pkg::side_t                        side_o,
  output logic [ccgf_pkg::NUM_LANE-1:0][WW-1:0]  weight_o
);

  localparam int XW = (DW > ccgf_pkg::COORD_W) ? DW : ccgf_pkg::COORD_W;

  ccgf_pkg::side_t                        side_a;
  logic                                   in_area;
  logic                                   degenerate;
  logic                                   flat_y;
  logic                                   tri_a;
  logic [DW-1:0]                          dx_a;
  logic [DW-1:0]                          dy_a;
  logic [DW-1:0]                          ex_a;
  logic [DW-1:0]                          ey_a;
  logic [DW-1:0]                          rx_a;
  logic [DW-1:0]                          ry_a;
  logic [ccgf_pkg::NUM_LANE-1:0][WW-1:0]  prod_nxt;

  ccgf_pkg::side_t                        side_b_r;
  logic [ccgf_pkg::NUM_LANE-1:0][WW-1:0]  prod_b_r;

  ccgf_pkg::side_t                        side_c_nxt;
  logic [ccgf_pkg::NUM_LANE-1:0][WW-1:0]  weight_c_nxt;
  logic [WW:0]                            tri_sum;
  ccgf_pkg::side_t                        side_c_r;
  logic [ccgf_pkg::NUM_LANE-1:0][WW-1:0]  weight_c_r;

  // First stage: classify the pixel and form the four corner weights as products.
  always_comb begin
    in_area    = (XW'(x_i) <= XW'(wm1_i)) && (XW'(y_i) <= XW'(hm1_i));
    degenerate = (wm1_i == '0) || (hm1_i == '0);
    side_a.valid = valid_i;
    side_a.kind  = ccgf_pkg::KIND_HOLE;
    side_a.solid = '0;
    if (in_area) begin
      unique case (count_i)
        ccgf_pkg::COUNT_BG: begin
          side_a.kind  = ccgf_pkg::KIND_SOLID;
          side_a.solid = bg_i;
        end
        ccgf_pkg::COUNT_FLAT: begin
          side_a.kind  = ccgf_pkg::KIND_SOLID;
          side_a.solid = flat_i;
        end
        ccgf_pkg::COUNT_TRI: begin
          if (degenerate) begin
            side_a.kind  = ccgf_pkg::KIND_SOLID;
            side_a.solid = bg_i;
          end else begin
            side_a.kind = ccgf_pkg::KIND_TRI;
          end
        end
        default: begin
          side_a.kind = ccgf_pkg::KIND_BLEND;
        end
      endcase
    end

    // The horizontal blend is the bilinear one with a single row.
    flat_y = (count_i == ccgf_pkg::COUNT_HBLEND) || (hm1_i == '0);
    dx_a   = (wm1_i == '0) ? DW'(1) : wm1_i;
    ex_a   = (wm1_i == '0) ? '0 : DW'(x_i);
    dy_a   = flat_y ? DW'(1) : hm1_i;
    ey_a   = flat_y ? '0 : DW'(y_i);
    rx_a   = dx_a - ex_a;
    ry_a   = dy_a - ey_a;
    tri_a  = (side_a.kind == ccgf_pkg::KIND_TRI);

    // For the triangle, lanes one and two give the top-right and bottom-left numerators.
    prod_nxt[0] = WW'(rx_a) * WW'(ry_a);
    prod_nxt[1] = WW'(ex_a) * WW'(tri_a ? dy_a : ry_a);
    prod_nxt[2] = WW'(tri_a ? dx_a : rx_a) * WW'(ey_a);
    prod_nxt[3] = WW'(ex_a) * WW'(ey_a);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_b_r <= '0;
    end else begin
      side_b_r <= side_a;
    end
  end

  always_ff @(posedge clk) begin
    prod_b_r <= prod_nxt;
  end

  // Second stage: the triangle test and the top-left weight that is left over.
  always_comb begin
    side_c_nxt   = side_b_r;
    weight_c_nxt = prod_b_r;
    tri_sum      = {1'b0, prod_b_r[1]} + {1'b0, prod_b_r[2]};
    if (side_b_r.kind == ccgf_pkg::KIND_TRI) begin
      if (tri_sum > {1'b0, div_i}) begin
        side_c_nxt.kind = ccgf_pkg::KIND_HOLE;
      end else begin
        side_c_nxt.kind = ccgf_pkg::KIND_BLEND;
      end
      weight_c_nxt[0] = div_i - prod_b_r[1] - prod_b_r[2];
      weight_c_nxt[3] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_c_r <= '0;
    end else begin
      side_c_r <= side_c_nxt;
    end
  end

  always_ff @(posedge clk) begin
    weight_c_r <= weight_c_nxt;
  end

  assign side_o   = side_c_r;
  assign weight_o = weight_c_r;

endmodule

`default_nettype wire

FILE: rtl/ccgf_div_pipe.sv
`default_nettype none

module ccgf_div_pipe #(
  parameter int NW  = 32,
  parameter int DVW = 24,
  parameter int QW  = ccgf_pkg::CH_W
) (
  input  logic           clk,
  input  logic [NW-1:0]  num_i,
  input  logic [DVW-1:0] div_i,
  output logic [QW-1:0]  quo_o
);

  // The numerator is below 2^QW times the divisor, so QW restoring steps suffice.
  logic [NW-1:0] rem_r [QW-1];
  logic [QW-1:0] quo_r [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [NW-1:0] rem_in;
    logic [NW-1:0] shifted;
    logic [QW-1:0] quo_in;
    logic          take;

    if (s == 0) begin : g_first
      assign rem_in = num_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign quo_in = quo_r[s-1];
    end

    assign shifted = NW'(div_i) << (QW - 1 - s);
    assign take    = (rem_in >= shifted);

    always_ff @(posedge clk) begin
      quo_r[s] <= {quo_in[QW-2:0], take};
    end

    if (s < QW - 1) begin : g_rem
      logic [NW-1:0] trial;

      assign trial = rem_in - shifted;

      always_ff @(posedge clk) begin
        rem_r[s] <= take ? trial : rem_in;
      end
    end
  end

  assign quo_o = quo_r[QW-1];

endmodule

`default_nettype wire

FILE: rtl/ccgf_checker.sv
`default_nettype none

`include "corner_color_gradient_fill_top_defines.svh"

module ccgf_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             start,
  input wire logic                             busy,
  input wire logic                             out_valid,
  input wire logic [ccgf_pkg::CH_W-1:0]        out_red,
  input wire logic [ccgf_pkg::CH_W-1:0]        out_green,
  input wire logic [ccgf_pkg::CH_W-1:0]        out_blue,
  input wire logic                             out_written,
  input wire logic                             cfg_we
);

  logic item_taken;

  assign item_taken = start && !busy;

  // Every item taken gives exactly one result after the fixed latency.
  `CCGF_ASSERT_DELAY(a_result_follows_item, clk, rst_n, item_taken, ccgf_pkg::LATENCY, out_valid, "item without result")
  `CCGF_ASSERT_IMP(a_result_has_item, clk, rst_n, out_valid, $past(item_taken, ccgf_pkg::LATENCY), "result without item")

  // A pixel left unwritten carries no colour.
  `CCGF_ASSERT_IMP(a_hole_is_black, clk, rst_n, out_valid && !out_written, (out_red == '0) && (out_green == '0) && (out_blue == '0), "unwritten pixel with colour")

  // A configuration write sets busy in the cycle after it, holding off the next item.
  `CCGF_ASSERT_NEXT(a_busy_after_write, clk, rst_n, cfg_we, busy, "item possible right after a write")

endmodule

bind corner_color_gradient_fill_top ccgf_checker u_checker (.*);

`default_nettype wire
